// File: sv/les_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// Shared types and constants of the linear envelope shaper.
// ----------------------------------------------------------------------------
package les_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 24;
    localparam int REGION_W = 2;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = FRAC_W + 1;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int DCNT_W   = $clog2(FRAC_W + 1);

    // apb port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_SUSTAIN = 2'd1;
    localparam logic [1:0] REG_DECAY   = 2'd2;
    localparam logic [1:0] REG_LEN     = 2'd3;

    // region codes
    localparam logic [REGION_W-1:0] REGION_ATTACK  = 2'd0;
    localparam logic [REGION_W-1:0] REGION_SUSTAIN = 2'd1;
    localparam logic [REGION_W-1:0] REGION_DECAY   = 2'd2;
    localparam logic [REGION_W-1:0] REGION_SILENT  = 2'd3;

    // unity gain in unsigned q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

    typedef struct packed {
        logic [CFG_W-1:0] attack;
        logic [CFG_W-1:0] sustain;
        logic [CFG_W-1:0] decay;
        logic [CFG_W-1:0] buffer_len;
    } cfg_t;

endpackage

// File: sv/linear_envelope_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_envelope_shaper
// Scales signed q1.23 samples by a linear attack-sustain-decay envelope.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. A sample in the attack or decay region
// passes from its transfer in through setup (clipped region ends, region
// compare, divider operands), the serial gain divider at one quotient bit
// per cycle, a done step, a multiply, an output load and the idle state
// that takes the next sample. Sustain and silent samples bypass the
// divider. The result sits in an output register; if it is still held
// when the next result is ready, the block waits for the output transfer
// before taking a new sample.
// ----------------------------------------------------------------------------
module linear_envelope_shaper #(
    parameter int LEN_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [les_pkg::APB_AW-1:0]         paddr,
    input  logic [les_pkg::APB_DW-1:0]         pwdata,
    output logic [les_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [les_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                               first,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [les_pkg::SAMPLE_W-1:0] sample_out,
    output logic [les_pkg::REGION_W-1:0]       region
);
    import les_pkg::*;

    localparam int CMP_W  = (LEN_BITS > CFG_W + 2) ? LEN_BITS : CFG_W + 2;
    localparam int ST_W   = 4;

    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_SUM1  = 4'd1;
    localparam logic [ST_W-1:0] ST_SUM2  = 4'd2;
    localparam logic [ST_W-1:0] ST_CLIP  = 4'd3;
    localparam logic [ST_W-1:0] ST_CLASS = 4'd4;
    localparam logic [ST_W-1:0] ST_PREP  = 4'd5;
    localparam logic [ST_W-1:0] ST_DIV   = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL   = 4'd7;
    localparam logic [ST_W-1:0] ST_DONE  = 4'd8;

    cfg_t                       cfg;
    logic [ST_W-1:0]            state_reg;
    logic [ST_W-1:0]            state_next;
    logic [LEN_BITS-1:0]        position_reg;
    logic [LEN_BITS-1:0]        position_next;
    logic [LEN_BITS-1:0]        pos_reg;
    logic [LEN_BITS-1:0]        pos_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic [CMP_W-1:0]           sum_reg;
    logic [CMP_W-1:0]           sum_next;
    logic [LEN_BITS-1:0]        a_reg;
    logic [LEN_BITS-1:0]        a_next;
    logic [LEN_BITS-1:0]        s_reg;
    logic [LEN_BITS-1:0]        s_next;
    logic [LEN_BITS-1:0]        d_reg;
    logic [LEN_BITS-1:0]        d_next;
    logic [REGION_W-1:0]        region_reg;
    logic [REGION_W-1:0]        region_next;
    logic [GAIN_W-1:0]          gain_reg;
    logic [GAIN_W-1:0]          gain_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic signed [SAMPLE_W-1:0] sample_out_next;
    logic [REGION_W-1:0]        region_out_reg;
    logic [REGION_W-1:0]        region_out_next;

    logic [LEN_BITS+CFG_W-1:0]  len_wide;
    logic [LEN_BITS-1:0]        len;
    logic [CMP_W-1:0]           len_c;
    logic [CMP_W-1:0]           attack_c;
    logic [CMP_W-1:0]           min_c;
    logic [LEN_BITS:0]          pos_inc;
    logic                       in_xfer;
    logic                       out_xfer;
    logic                       load_out;
    logic                       div_start;
    logic [LEN_BITS-1:0]        div_num;
    logic [LEN_BITS-1:0]        div_den;
    logic                       div_done;
    logic [FRAC_W-1:0]          div_quot;

    les_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    les_divider #(
        .LEN_BITS (LEN_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // buffer length cut to the position width
    assign len_wide = {{LEN_BITS{1'b0}}, cfg.buffer_len};
    assign len      = len_wide[LEN_BITS-1:0];
    assign len_c    = CMP_W'(len);
    assign attack_c = CMP_W'(cfg.attack);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // shared clip compare against the buffer length
    always_comb
    begin
        unique case (state_reg)
            ST_SUM1: min_c = (attack_c < len_c) ? attack_c : len_c;
            default: min_c = (sum_reg < len_c) ? sum_reg : len_c;
        endcase
    end

    // divider operands
    assign div_start = (state_reg == ST_PREP) &&
                       ((region_reg == REGION_ATTACK) || (region_reg == REGION_DECAY));
    assign div_num   = (region_reg == REGION_ATTACK) ? pos_reg : (pos_reg - s_reg);
    assign div_den   = (region_reg == REGION_ATTACK) ? a_reg : (d_reg - s_reg);

    assign pos_inc = {1'b0, pos_reg} + (LEN_BITS+1)'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        position_next   = position_reg;
        pos_next        = pos_reg;
        sample_next     = sample_reg;
        sum_next        = sum_reg;
        a_next          = a_reg;
        s_next          = s_reg;
        d_next          = d_reg;
        region_next     = region_reg;
        gain_next       = gain_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        region_out_next = region_out_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    pos_next    = first ? '0 : position_reg;
                    sample_next = sample_in;
                    state_next  = ST_SUM1;
                end
            end
            ST_SUM1:
            begin
                sum_next   = attack_c + CMP_W'(cfg.sustain);
                a_next     = min_c[LEN_BITS-1:0];
                state_next = ST_SUM2;
            end
            ST_SUM2:
            begin
                sum_next   = sum_reg + CMP_W'(cfg.decay);
                s_next     = min_c[LEN_BITS-1:0];
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                d_next     = min_c[LEN_BITS-1:0];
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (pos_reg < a_reg)
                begin
                    region_next = REGION_ATTACK;
                end
                else if (pos_reg < s_reg)
                begin
                    region_next = REGION_SUSTAIN;
                end
                else if (pos_reg < d_reg)
                begin
                    region_next = REGION_DECAY;
                end
                else
                begin
                    region_next = REGION_SILENT;
                end
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    gain_next  = (region_reg == REGION_SUSTAIN) ? GAIN_ONE : '0;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (region_reg == REGION_ATTACK)
                    begin
                        gain_next = GAIN_W'(div_quot);
                    end
                    else
                    begin
                        gain_next = GAIN_ONE - GAIN_W'(div_quot);
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(sample_reg * $signed({1'b0, gain_reg}));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = prod_reg[FRAC_W +: SAMPLE_W];
                    region_out_next = region_reg;
                    position_next   = (pos_inc < {1'b0, len}) ?
                                      pos_inc[LEN_BITS-1:0] : len;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        sample_reg     <= sample_next;
        sum_reg        <= sum_next;
        a_reg          <= a_next;
        s_reg          <= s_next;
        d_reg          <= d_next;
        region_reg     <= region_next;
        gain_reg       <= gain_next;
        prod_reg       <= prod_next;
        sample_out_reg <= sample_out_next;
        region_out_reg <= region_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign region     = region_out_reg;

endmodule

// File: sv/les_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_regs
// APB register file holding the envelope lengths and the buffer length.
// ----------------------------------------------------------------------------
module les_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [les_pkg::APB_AW-1:0] paddr,
    input  logic [les_pkg::APB_DW-1:0] pwdata,
    output logic [les_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output les_pkg::cfg_t              cfg
);
    import les_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [1:0]       index;
    logic             wr_en;
    logic [CFG_W-1:0] rd_value;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_ATTACK:  cfg_next.attack     = pwdata[CFG_W-1:0];
                REG_SUSTAIN: cfg_next.sustain    = pwdata[CFG_W-1:0];
                REG_DECAY:   cfg_next.decay      = pwdata[CFG_W-1:0];
                REG_LEN:     cfg_next.buffer_len = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (index)
            REG_ATTACK:  rd_value = cfg_reg.attack;
            REG_SUSTAIN: rd_value = cfg_reg.sustain;
            REG_DECAY:   rd_value = cfg_reg.decay;
            REG_LEN:     rd_value = cfg_reg.buffer_len;
        endcase
    end

    assign prdata = APB_DW'(rd_value);
    assign cfg    = cfg_reg;

endmodule

// File: sv/les_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_divider
// Serial restoring divider giving floor(num * 2^16 / den) for num < den.
// ----------------------------------------------------------------------------
module les_divider #(
    parameter int LEN_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [LEN_BITS-1:0]        num,
    input  logic [LEN_BITS-1:0]        den,
    output logic                       done,
    output logic [les_pkg::FRAC_W-1:0] quotient
);
    import les_pkg::*;

    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_next;
    logic [LEN_BITS-1:0] den_reg;
    logic [LEN_BITS-1:0] den_next;
    logic [FRAC_W-1:0]   quot_reg;
    logic [FRAC_W-1:0]   quot_next;
    logic [DCNT_W-1:0]   cnt_reg;
    logic [DCNT_W-1:0]   cnt_next;
    logic                done_reg;
    logic                done_next;
    logic [LEN_BITS:0]   shifted;
    logic [LEN_BITS:0]   diff;
    logic                fits;

    // one quotient bit per cycle: shift, trial subtract, restore
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num;
            den_next = den;
            cnt_next = DCNT_W'(FRAC_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
            quot_next = {quot_reg[FRAC_W-2:0], fits};
            cnt_next  = cnt_reg - DCNT_W'(1);
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
